@@ src/qttc_pkg.sv @@
`timescale 1ns / 1ps
package qttc_pkg;

	// working word: wide enough for any product taken back to the number range
	localparam int IW        = 66;
	localparam int NUM_TERMS = 10;
	localparam int US_PER_S  = 1000000;
	localparam int PCW       = 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_MULF,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_MOVE,
		OP_ADD,
		OP_SUB,
		OP_QMUL,
		OP_IMUL,
		OP_RAW,
		OP_CLAMPD,
		OP_CLAMP32,
		OP_POLYP,
		OP_POLYV,
		OP_POLYA,
		OP_DIVS,
		OP_DIVT,
		OP_PAST,
		OP_DONE
	} op_t;

	typedef enum logic [5:0] {
		R_ZERO, R_S, R_S2, R_S3, R_S4, R_S5, R_PP, R_PV, R_PA, R_INVT, R_TUS,
		R_TMP, R_ACC, R_SPAN0, R_SPAN1, R_START0, R_START1, R_TGT0, R_TGT1,
		R_Q0, R_Q1, R_QV0, R_QV1, R_QD0, R_QD1, R_VD0, R_VD1, R_AD0, R_AD1,
		R_E0, R_E1, R_QR10, R_QR11, R_SL0, R_SL1, R_QR20, R_QR21,
		R_DYN0, R_DYN1, R_DYN2, R_DYN3, R_DYN4, R_DYN5, R_DYN6, R_DYN7,
		R_DYN8, R_DYN9, R_KC, R_KD, R_TICK, R_DT, R_TAU0, R_TAU1
	} src_t;

	typedef struct packed {
		op_t  op;
		src_t a;
		src_t b;
		src_t d;
		logic cond_new;
	} instr_t;

	localparam logic [PCW-1:0] PC_ERR = 7'd30;

	function automatic instr_t mk(op_t op, src_t a, src_t b, src_t d, logic cn);
		instr_t r;
		r.op = op;
		r.a = a;
		r.b = b;
		r.d = d;
		r.cond_new = cn;
		return r;
	endfunction

	// microprogram for one control step
	function automatic instr_t prog(logic [PCW-1:0] pc);
		instr_t r;
		case (pc)
			7'd0:  r = mk(OP_MOVE,  R_Q0,    R_ZERO, R_START0, 1'b1);
			7'd1:  r = mk(OP_SUB,   R_TGT0,  R_Q0,   R_SPAN0,  1'b1);
			7'd2:  r = mk(OP_MOVE,  R_Q1,    R_ZERO, R_START1, 1'b1);
			7'd3:  r = mk(OP_SUB,   R_TGT1,  R_Q1,   R_SPAN1,  1'b1);
			7'd4:  r = mk(OP_RAW,   R_TICK,  R_DT,   R_TUS,    1'b0);
			7'd5:  r = mk(OP_PAST,  R_ZERO,  R_ZERO, R_ZERO,   1'b0);
			7'd6:  r = mk(OP_DIVS,  R_ZERO,  R_ZERO, R_S,      1'b0);
			7'd7:  r = mk(OP_DIVT,  R_ZERO,  R_ZERO, R_INVT,   1'b0);
			7'd8:  r = mk(OP_CLAMPD, R_INVT, R_ZERO, R_INVT,   1'b0);
			7'd9:  r = mk(OP_QMUL,  R_S,     R_S,    R_S2,     1'b0);
			7'd10: r = mk(OP_QMUL,  R_S2,    R_S,    R_S3,     1'b0);
			7'd11: r = mk(OP_QMUL,  R_S3,    R_S,    R_S4,     1'b0);
			7'd12: r = mk(OP_QMUL,  R_S4,    R_S,    R_S5,     1'b0);
			7'd13: r = mk(OP_POLYP, R_ZERO,  R_ZERO, R_PP,     1'b0);
			7'd14: r = mk(OP_POLYV, R_ZERO,  R_ZERO, R_PV,     1'b0);
			7'd15: r = mk(OP_POLYA, R_ZERO,  R_ZERO, R_PA,     1'b0);
			7'd16: r = mk(OP_QMUL,  R_SPAN0, R_PP,   R_TMP,    1'b0);
			7'd17: r = mk(OP_ADD,   R_START0, R_TMP, R_QD0,    1'b0);
			7'd18: r = mk(OP_QMUL,  R_SPAN1, R_PP,   R_TMP,    1'b0);
			7'd19: r = mk(OP_ADD,   R_START1, R_TMP, R_QD1,    1'b0);
			7'd20: r = mk(OP_QMUL,  R_SPAN0, R_PV,   R_TMP,    1'b0);
			7'd21: r = mk(OP_QMUL,  R_TMP,   R_INVT, R_VD0,    1'b0);
			7'd22: r = mk(OP_QMUL,  R_SPAN1, R_PV,   R_TMP,    1'b0);
			7'd23: r = mk(OP_QMUL,  R_TMP,   R_INVT, R_VD1,    1'b0);
			7'd24: r = mk(OP_QMUL,  R_SPAN0, R_PA,   R_TMP,    1'b0);
			7'd25: r = mk(OP_QMUL,  R_TMP,   R_INVT, R_TMP,    1'b0);
			7'd26: r = mk(OP_QMUL,  R_TMP,   R_INVT, R_AD0,    1'b0);
			7'd27: r = mk(OP_QMUL,  R_SPAN1, R_PA,   R_TMP,    1'b0);
			7'd28: r = mk(OP_QMUL,  R_TMP,   R_INVT, R_TMP,    1'b0);
			7'd29: r = mk(OP_QMUL,  R_TMP,   R_INVT, R_AD1,    1'b0);
			7'd30: r = mk(OP_SUB,   R_QD0,   R_Q0,   R_E0,     1'b0);
			7'd31: r = mk(OP_IMUL,  R_E0,    R_KC,   R_TMP,    1'b0);
			7'd32: r = mk(OP_ADD,   R_VD0,   R_TMP,  R_QR10,   1'b0);
			7'd33: r = mk(OP_SUB,   R_QR10,  R_QV0,  R_SL0,    1'b0);
			7'd34: r = mk(OP_SUB,   R_VD0,   R_QV0,  R_TMP,    1'b0);
			7'd35: r = mk(OP_IMUL,  R_TMP,   R_KC,   R_TMP,    1'b0);
			7'd36: r = mk(OP_ADD,   R_AD0,   R_TMP,  R_QR20,   1'b0);
			7'd37: r = mk(OP_SUB,   R_QD1,   R_Q1,   R_E1,     1'b0);
			7'd38: r = mk(OP_IMUL,  R_E1,    R_KC,   R_TMP,    1'b0);
			7'd39: r = mk(OP_ADD,   R_VD1,   R_TMP,  R_QR11,   1'b0);
			7'd40: r = mk(OP_SUB,   R_QR11,  R_QV1,  R_SL1,    1'b0);
			7'd41: r = mk(OP_SUB,   R_VD1,   R_QV1,  R_TMP,    1'b0);
			7'd42: r = mk(OP_IMUL,  R_TMP,   R_KC,   R_TMP,    1'b0);
			7'd43: r = mk(OP_ADD,   R_AD1,   R_TMP,  R_QR21,   1'b0);
			7'd44: r = mk(OP_QMUL,  R_DYN0,  R_QR20, R_ACC,    1'b0);
			7'd45: r = mk(OP_QMUL,  R_DYN1,  R_QR21, R_TMP,    1'b0);
			7'd46: r = mk(OP_ADD,   R_ACC,   R_TMP,  R_ACC,    1'b0);
			7'd47: r = mk(OP_QMUL,  R_DYN4,  R_QR10, R_TMP,    1'b0);
			7'd48: r = mk(OP_ADD,   R_ACC,   R_TMP,  R_ACC,    1'b0);
			7'd49: r = mk(OP_QMUL,  R_DYN5,  R_QR11, R_TMP,    1'b0);
			7'd50: r = mk(OP_ADD,   R_ACC,   R_TMP,  R_ACC,    1'b0);
			7'd51: r = mk(OP_ADD,   R_ACC,   R_DYN8, R_ACC,    1'b0);
			7'd52: r = mk(OP_ADD,   R_ACC,   R_E0,   R_ACC,    1'b0);
			7'd53: r = mk(OP_IMUL,  R_SL0,   R_KD,   R_TMP,    1'b0);
			7'd54: r = mk(OP_ADD,   R_ACC,   R_TMP,  R_ACC,    1'b0);
			7'd55: r = mk(OP_CLAMP32, R_ACC, R_ZERO, R_TAU0,   1'b0);
			7'd56: r = mk(OP_QMUL,  R_DYN2,  R_QR20, R_ACC,    1'b0);
			7'd57: r = mk(OP_QMUL,  R_DYN3,  R_QR21, R_TMP,    1'b0);
			7'd58: r = mk(OP_ADD,   R_ACC,   R_TMP,  R_ACC,    1'b0);
			7'd59: r = mk(OP_QMUL,  R_DYN6,  R_QR10, R_TMP,    1'b0);
			7'd60: r = mk(OP_ADD,   R_ACC,   R_TMP,  R_ACC,    1'b0);
			7'd61: r = mk(OP_QMUL,  R_DYN7,  R_QR11, R_TMP,    1'b0);
			7'd62: r = mk(OP_ADD,   R_ACC,   R_TMP,  R_ACC,    1'b0);
			7'd63: r = mk(OP_ADD,   R_ACC,   R_DYN9, R_ACC,    1'b0);
			7'd64: r = mk(OP_ADD,   R_ACC,   R_E1,   R_ACC,    1'b0);
			7'd65: r = mk(OP_IMUL,  R_SL1,   R_KD,   R_TMP,    1'b0);
			7'd66: r = mk(OP_ADD,   R_ACC,   R_TMP,  R_ACC,    1'b0);
			7'd67: r = mk(OP_CLAMP32, R_ACC, R_ZERO, R_TAU1,   1'b0);
			default: r = mk(OP_DONE, R_ZERO, R_ZERO, R_ZERO,   1'b0);
		endcase
		return r;
	endfunction

endpackage

@@ src/qttc_if.sv @@
`timescale 1ns / 1ps
interface qttc_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [3:0]  coef_index;
	logic [31:0] coef_value;
	logic        new_target;
	logic [31:0] target_pos_1;
	logic [31:0] target_pos_2;
	logic [31:0] joint_pos_1;
	logic [31:0] joint_pos_2;
	logic [31:0] joint_vel_1;
	logic [31:0] joint_vel_2;

	modport source (output valid, op, coef_index, coef_value, new_target, target_pos_1,
		target_pos_2, joint_pos_1, joint_pos_2, joint_vel_1, joint_vel_2, input ready);
	modport sink (input valid, op, coef_index, coef_value, new_target, target_pos_1,
		target_pos_2, joint_pos_1, joint_pos_2, joint_vel_1, joint_vel_2, output ready);
endinterface

interface qttc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] torque_1;
	logic [31:0] torque_2;
	logic        clipped;

	modport source (output valid, torque_1, torque_2, clipped, input ready);
	modport sink (input valid, torque_1, torque_2, clipped, output ready);
endinterface

@@ src/quintic_trajectory_torque_control_core.sv @@
`timescale 1ns / 1ps
// Two-joint quintic trajectory torque controller. Load transactions (op 0) write one
// dynamics coefficient on acceptance and return nothing. A control step (op 1) runs
// a microprogram on one shared multiplier and one restoring divider and returns one
// torque pair. Each multiply is an issue step, four 32x32 partial products and a
// truncation/saturation step; each divide is an initialising step and then one step
// per quotient bit. A step past the trajectory end skips the divides and the
// polynomial evaluation. The input is not ready while a step runs, and a step
// finishes only once the previous result has been taken.
module quintic_trajectory_torque_control_core #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	qttc_in_if.sink     req,
	qttc_out_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import qttc_pkg::*;

	localparam logic signed [IW-1:0] QMAX =
		$signed((IW'(1) << (DATA_WIDTH - 1)) - IW'(1));
	localparam logic signed [IW-1:0] QMIN = -QMAX - IW'(1);
	localparam logic signed [IW-1:0] T32MAX = IW'(33'sh0_7FFF_FFFF);
	localparam logic signed [IW-1:0] T32MIN = -T32MAX - IW'(1);
	localparam int NUMW = 24 + FRAC_BITS;
	localparam int DCW  = $clog2(NUMW + 1);

	typedef struct packed {
		logic                 hit;
		logic signed [IW-1:0] val;
	} satv_t;

	function automatic satv_t clampv(logic signed [IW-1:0] v, logic signed [IW-1:0] lo,
		logic signed [IW-1:0] hi);
		satv_t r;
		r.hit = (v > hi) || (v < lo);
		r.val = (v > hi) ? hi : ((v < lo) ? lo : v);
		return r;
	endfunction

	// configuration
	logic [19:0] dt_q;
	logic [23:0] tt_q;
	logic [9:0]  kc_q;
	logic [9:0]  kd_q;
	logic        cfg_wr;
	logic [23:0] tt_eff;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign tt_eff = (tt_q == 24'd0) ? 24'd1 : tt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= 20'd1000;
			tt_q <= 24'd100000;
			kc_q <= 10'd10;
			kd_q <= 10'd10;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				2'd0: dt_q <= pwdata[19:0];
				2'd1: tt_q <= pwdata[23:0];
				2'd2: kc_q <= pwdata[9:0];
				2'd3: kd_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			2'd0: prdata = {12'd0, dt_q};
			2'd1: prdata = {8'd0, tt_q};
			2'd2: prdata = {22'd0, kc_q};
			2'd3: prdata = {22'd0, kd_q};
			default: prdata = 32'd0;
		endcase
	end

	// state
	state_t state_q, state_d;
	logic [PCW-1:0] pc_q;
	logic           newt_q;
	logic           sat_q;
	logic [31:0]    tick_q;
	logic signed [DATA_WIDTH-1:0] start_q [2];
	logic signed [DATA_WIDTH-1:0] span_q [2];
	logic signed [DATA_WIDTH-1:0] dyn_q [NUM_TERMS];

	logic signed [IW-1:0] s_q, s2_q, s3_q, s4_q, s5_q, pp_q, pv_q, pa_q, invt_q, tus_q;
	logic signed [IW-1:0] tmp_q, acc_q;
	logic signed [IW-1:0] tgt_q [2];
	logic signed [IW-1:0] jq_q [2];
	logic signed [IW-1:0] jv_q [2];
	logic signed [IW-1:0] qd_q [2];
	logic signed [IW-1:0] vd_q [2];
	logic signed [IW-1:0] ad_q [2];
	logic signed [IW-1:0] e_q [2];
	logic signed [IW-1:0] qr1_q [2];
	logic signed [IW-1:0] sl_q [2];
	logic signed [IW-1:0] qr2_q [2];
	logic [31:0]          tau_q [2];

	// shared multiplier
	logic [63:0]  mag_a_q, mag_b_q;
	logic         neg_q;
	logic [127:0] macc_q;
	logic [1:0]   ph_q;

	// divider
	logic [24:0]      rem_q;
	logic [NUMW-1:0]  num_q, quo_q;
	logic [DCW-1:0]   dcnt_q;

	logic out_valid_q;
	logic out_load;

	instr_t ins;
	assign ins = prog(pc_q);

	function automatic logic signed [IW-1:0] sel(src_t s);
		logic signed [IW-1:0] r;
		case (s)
			R_S:      r = s_q;
			R_S2:     r = s2_q;
			R_S3:     r = s3_q;
			R_S4:     r = s4_q;
			R_S5:     r = s5_q;
			R_PP:     r = pp_q;
			R_PV:     r = pv_q;
			R_PA:     r = pa_q;
			R_INVT:   r = invt_q;
			R_TUS:    r = tus_q;
			R_TMP:    r = tmp_q;
			R_ACC:    r = acc_q;
			R_SPAN0:  r = IW'(span_q[0]);
			R_SPAN1:  r = IW'(span_q[1]);
			R_START0: r = IW'(start_q[0]);
			R_START1: r = IW'(start_q[1]);
			R_TGT0:   r = tgt_q[0];
			R_TGT1:   r = tgt_q[1];
			R_Q0:     r = jq_q[0];
			R_Q1:     r = jq_q[1];
			R_QV0:    r = jv_q[0];
			R_QV1:    r = jv_q[1];
			R_QD0:    r = qd_q[0];
			R_QD1:    r = qd_q[1];
			R_VD0:    r = vd_q[0];
			R_VD1:    r = vd_q[1];
			R_AD0:    r = ad_q[0];
			R_AD1:    r = ad_q[1];
			R_E0:     r = e_q[0];
			R_E1:     r = e_q[1];
			R_QR10:   r = qr1_q[0];
			R_QR11:   r = qr1_q[1];
			R_SL0:    r = sl_q[0];
			R_SL1:    r = sl_q[1];
			R_QR20:   r = qr2_q[0];
			R_QR21:   r = qr2_q[1];
			R_DYN0:   r = IW'(dyn_q[0]);
			R_DYN1:   r = IW'(dyn_q[1]);
			R_DYN2:   r = IW'(dyn_q[2]);
			R_DYN3:   r = IW'(dyn_q[3]);
			R_DYN4:   r = IW'(dyn_q[4]);
			R_DYN5:   r = IW'(dyn_q[5]);
			R_DYN6:   r = IW'(dyn_q[6]);
			R_DYN7:   r = IW'(dyn_q[7]);
			R_DYN8:   r = IW'(dyn_q[8]);
			R_DYN9:   r = IW'(dyn_q[9]);
			R_KC:     r = $signed(IW'(kc_q));
			R_KD:     r = $signed(IW'(kd_q));
			R_TICK:   r = $signed(IW'(tick_q));
			R_DT:     r = $signed(IW'(dt_q));
			default:  r = '0;
		endcase
		return r;
	endfunction

	logic signed [IW-1:0] opa, opb;
	assign opa = sel(ins.a);
	assign opb = sel(ins.b);

	logic signed [IW-1:0] mag_a_full, mag_b_full;
	assign mag_a_full = opa[IW-1] ? -opa : opa;
	assign mag_b_full = opb[IW-1] ? -opb : opb;

	logic in_acc;
	assign req.ready = (state_q == ST_IDLE);
	assign in_acc = req.valid & req.ready;

	logic past;
	assign past = tus_q > $signed(IW'(tt_eff));

	logic mul_last, div_last;
	assign mul_last = (ph_q == 2'd3);
	assign div_last = (dcnt_q == DCW'(NUMW));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc && req.op) state_d = ST_EXEC;
			ST_EXEC: begin
				if (!(ins.cond_new && !newt_q)) begin
					case (ins.op)
						OP_QMUL, OP_IMUL, OP_RAW: state_d = ST_MUL;
						OP_DIVS, OP_DIVT:         state_d = ST_DIV;
						OP_DONE:                  state_d = ST_DONE;
						default:                  state_d = ST_EXEC;
					endcase
				end
			end
			ST_MUL:  if (mul_last) state_d = ST_MULF;
			ST_MULF: state_d = ST_EXEC;
			ST_DIV:  if (div_last) state_d = ST_EXEC;
			ST_DONE: if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	logic                 wr_en;
	src_t                 wr_dst;
	logic signed [IW-1:0] wr_data;
	logic                 wr_hit;
	logic                 pc_inc;

	logic [127:0]         mshift, mlimit;
	logic signed [IW-1:0] mres;
	satv_t                alu_r;

	always_comb begin
		mshift = (ins.op == OP_QMUL) ? (macc_q >> FRAC_BITS) : macc_q;
		mlimit = 128'(QMAX) + (neg_q ? 128'd1 : 128'd0);
		mres   = neg_q ? -$signed(mshift[IW-1:0]) : $signed(mshift[IW-1:0]);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_dst  = ins.d;
		wr_data = '0;
		wr_hit  = 1'b0;
		pc_inc  = 1'b0;
		alu_r   = '0;
		out_load = 1'b0;
		case (state_q)
			ST_EXEC: begin
				if (ins.cond_new && !newt_q) begin
					pc_inc = 1'b1;
				end else begin
					case (ins.op)
						OP_MOVE: begin
							wr_en = 1'b1;
							wr_data = opa;
							pc_inc = 1'b1;
						end
						OP_ADD, OP_SUB, OP_CLAMPD, OP_CLAMP32: begin
							if (ins.op == OP_ADD) alu_r = clampv(opa + opb, QMIN, QMAX);
							else if (ins.op == OP_SUB) alu_r = clampv(opa - opb, QMIN, QMAX);
							else if (ins.op == OP_CLAMPD) alu_r = clampv(opa, QMIN, QMAX);
							else alu_r = clampv(opa, T32MIN, T32MAX);
							wr_en = 1'b1;
							wr_data = alu_r.val;
							wr_hit = alu_r.hit;
							pc_inc = 1'b1;
						end
						OP_POLYP: begin
							wr_en = 1'b1;
							wr_data = (s3_q <<< 3) + (s3_q <<< 1) - ((s4_q <<< 4) - s4_q)
								+ (s5_q <<< 2) + (s5_q <<< 1);
							pc_inc = 1'b1;
						end
						OP_POLYV: begin
							wr_en = 1'b1;
							wr_data = ((s2_q - (s3_q <<< 1) + s4_q) <<< 5)
								- ((s2_q - (s3_q <<< 1) + s4_q) <<< 1);
							pc_inc = 1'b1;
						end
						OP_POLYA: begin
							wr_en = 1'b1;
							wr_data = ((s_q - (s2_q <<< 1) - s2_q + (s3_q <<< 1)) <<< 6)
								- ((s_q - (s2_q <<< 1) - s2_q + (s3_q <<< 1)) <<< 2);
							pc_inc = 1'b1;
						end
						OP_PAST: pc_inc = !past;
						default: ;
					endcase
				end
			end
			ST_MULF: begin
				wr_en = 1'b1;
				pc_inc = 1'b1;
				if (ins.op == OP_RAW) begin
					wr_data = $signed(macc_q[IW-1:0]);
				end else if (mshift > mlimit) begin
					wr_data = neg_q ? QMIN : QMAX;
					wr_hit = 1'b1;
				end else begin
					wr_data = mres;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					wr_en = 1'b1;
					wr_data = $signed(IW'(quo_q));
					pc_inc = 1'b1;
				end
			end
			ST_DONE: out_load = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			newt_q <= 1'b0;
			sat_q <= 1'b0;
			tick_q <= '0;
			start_q <= '{default: '0};
			span_q <= '{default: '0};
			dyn_q <= '{default: '0};
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pc_inc) pc_q <= pc_q + 1'b1;
			if (wr_hit) sat_q <= 1'b1;
			if (in_acc) begin
				if (!req.op) begin
					// load transaction: store the clamped coefficient
					if (req.coef_index < 4'(NUM_TERMS))
						dyn_q[req.coef_index] <= DATA_WIDTH'(clampv(
							IW'($signed(req.coef_value)), QMIN, QMAX).val);
				end else begin
					pc_q <= '0;
					newt_q <= req.new_target;
					if (req.new_target) tick_q <= '0;
					sat_q <= clampv(IW'($signed(req.target_pos_1)), QMIN, QMAX).hit
						| clampv(IW'($signed(req.target_pos_2)), QMIN, QMAX).hit
						| clampv(IW'($signed(req.joint_pos_1)), QMIN, QMAX).hit
						| clampv(IW'($signed(req.joint_pos_2)), QMIN, QMAX).hit
						| clampv(IW'($signed(req.joint_vel_1)), QMIN, QMAX).hit
						| clampv(IW'($signed(req.joint_vel_2)), QMIN, QMAX).hit;
				end
			end
			if (state_q == ST_EXEC && ins.op == OP_PAST && past && !ins.cond_new)
				pc_q <= PC_ERR;
			if (wr_en) begin
				case (wr_dst)
					R_START0: start_q[0] <= DATA_WIDTH'(wr_data);
					R_START1: start_q[1] <= DATA_WIDTH'(wr_data);
					R_SPAN0:  span_q[0] <= DATA_WIDTH'(wr_data);
					R_SPAN1:  span_q[1] <= DATA_WIDTH'(wr_data);
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (tick_q != 32'hFFFF_FFFF) tick_q <= tick_q + 32'd1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc && req.op) begin
			tgt_q[0] <= clampv(IW'($signed(req.target_pos_1)), QMIN, QMAX).val;
			tgt_q[1] <= clampv(IW'($signed(req.target_pos_2)), QMIN, QMAX).val;
			jq_q[0]  <= clampv(IW'($signed(req.joint_pos_1)), QMIN, QMAX).val;
			jq_q[1]  <= clampv(IW'($signed(req.joint_pos_2)), QMIN, QMAX).val;
			jv_q[0]  <= clampv(IW'($signed(req.joint_vel_1)), QMIN, QMAX).val;
			jv_q[1]  <= clampv(IW'($signed(req.joint_vel_2)), QMIN, QMAX).val;
		end
		// past the trajectory end: hold the target, zero velocity and acceleration
		if (state_q == ST_EXEC && ins.op == OP_PAST && past) begin
			qd_q[0] <= tgt_q[0];
			qd_q[1] <= tgt_q[1];
			vd_q[0] <= '0;
			vd_q[1] <= '0;
			ad_q[0] <= '0;
			ad_q[1] <= '0;
		end
		if (wr_en) begin
			case (wr_dst)
				R_S:    s_q <= wr_data;
				R_S2:   s2_q <= wr_data;
				R_S3:   s3_q <= wr_data;
				R_S4:   s4_q <= wr_data;
				R_S5:   s5_q <= wr_data;
				R_PP:   pp_q <= wr_data;
				R_PV:   pv_q <= wr_data;
				R_PA:   pa_q <= wr_data;
				R_INVT: invt_q <= wr_data;
				R_TUS:  tus_q <= wr_data;
				R_TMP:  tmp_q <= wr_data;
				R_ACC:  acc_q <= wr_data;
				R_QD0:  qd_q[0] <= wr_data;
				R_QD1:  qd_q[1] <= wr_data;
				R_VD0:  vd_q[0] <= wr_data;
				R_VD1:  vd_q[1] <= wr_data;
				R_AD0:  ad_q[0] <= wr_data;
				R_AD1:  ad_q[1] <= wr_data;
				R_E0:   e_q[0] <= wr_data;
				R_E1:   e_q[1] <= wr_data;
				R_QR10: qr1_q[0] <= wr_data;
				R_QR11: qr1_q[1] <= wr_data;
				R_SL0:  sl_q[0] <= wr_data;
				R_SL1:  sl_q[1] <= wr_data;
				R_QR20: qr2_q[0] <= wr_data;
				R_QR21: qr2_q[1] <= wr_data;
				R_TAU0: tau_q[0] <= wr_data[31:0];
				R_TAU1: tau_q[1] <= wr_data[31:0];
				default: ;
			endcase
		end
		// multiplier: sign and magnitude, four 32x32 partial products
		if (state_q == ST_EXEC && (ins.op == OP_QMUL || ins.op == OP_IMUL
			|| ins.op == OP_RAW)) begin
			mag_a_q <= mag_a_full[63:0];
			mag_b_q <= mag_b_full[63:0];
			neg_q   <= opa[IW-1] ^ opb[IW-1];
			macc_q  <= '0;
			ph_q    <= 2'd0;
		end else if (state_q == ST_MUL) begin
			macc_q <= macc_q + (128'((ph_q[1] ? mag_a_q[63:32] : mag_a_q[31:0])
				* (ph_q[0] ? mag_b_q[63:32] : mag_b_q[31:0]))
				<< {(2'(ph_q[1]) + 2'(ph_q[0])), 5'd0});
			ph_q <= ph_q + 2'd1;
		end
		// divider: one quotient bit a cycle
		if (state_q == ST_EXEC && (ins.op == OP_DIVS || ins.op == OP_DIVT)) begin
			num_q  <= (ins.op == OP_DIVS) ? (NUMW'(tus_q[23:0]) << FRAC_BITS)
				: (NUMW'(US_PER_S) << FRAC_BITS);
			rem_q  <= '0;
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (state_q == ST_DIV && !div_last) begin
			if ({rem_q[23:0], num_q[NUMW-1]} >= {1'b0, tt_eff}) begin
				rem_q <= {rem_q[23:0], num_q[NUMW-1]} - {1'b0, tt_eff};
				quo_q <= {quo_q[NUMW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[23:0], num_q[NUMW-1]};
				quo_q <= {quo_q[NUMW-2:0], 1'b0};
			end
			num_q  <= num_q << 1;
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	logic [31:0] t1_q, t2_q;
	logic        clip_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			t1_q   <= tau_q[0];
			t2_q   <= tau_q[1];
			clip_q <= sat_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.torque_1 = t1_q;
	assign rsp.torque_2 = t2_q;
	assign rsp.clipped  = clip_q;

endmodule
